// ----- hw/rtl/sid_pkg.sv -----
// session slot table package: transaction structs, command and status codes
// and the session type mapping; no dependencies
package sid_pkg;

  localparam int SESSION_SLOTS_DEF = 4;
  localparam int ID_W = 32;
  localparam int ENTRY_W = ID_W + 3;

  localparam logic [ID_W-1:0] ID_FREE   = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0] HIGH_HALF = 32'hFFFF_0000;
  localparam logic [ID_W-1:0] LOW_HALF  = 32'h0000_FFFF;
  localparam logic [15:0]     HALF_NONE = 16'hFFFF;

  localparam logic [2:0] CMD_LOOKUP    = 3'd0;
  localparam logic [2:0] CMD_ASSIGN    = 3'd1;
  localparam logic [2:0] CMD_FREE      = 3'd2;
  localparam logic [2:0] CMD_ALLOC_REQ = 3'd3;
  localparam logic [2:0] CMD_ALLOC_RSP = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic CFG_PEER_CAPS  = 1'b0;
  localparam logic CFG_LOCAL_CAPS = 1'b1;

  localparam logic [1:0] TYPE_NONE    = 2'd0;
  localparam logic [1:0] TYPE_MAC     = 2'd1;
  localparam logic [1:0] TYPE_ENC_MAC = 2'd2;
  localparam logic [1:0] TYPE_BAD     = 2'd3;

  typedef struct packed {
    logic [2:0]      command;
    logic [ID_W-1:0] sess_id;
    logic            use_psk;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  slot_index;
    logic [15:0] half_id;
    logic        entry_use_psk;
    logic [1:0]  entry_session_type;
  } out_t;

  function automatic logic [1:0] caps_to_type(input logic [1:0] both);
    logic [1:0] t;
    case (both)
      2'b00:   t = TYPE_NONE;
      2'b11:   t = TYPE_ENC_MAC;
      2'b10:   t = TYPE_MAC;
      default: t = TYPE_BAD;
    endcase
    return t;
  endfunction

endpackage

// ----- hw/rtl/sid_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module sid_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sid_match.sv -----
// shared masked identifier comparator used for every slot walk
// depends on sid_pkg
module sid_match (
  input  logic [sid_pkg::ID_W-1:0] data,
  input  logic [sid_pkg::ID_W-1:0] key,
  input  logic [sid_pkg::ID_W-1:0] mask,
  output logic                     hit
);

  assign hit = (((data ^ key) & mask) == '0);

endmodule

// ----- hw/rtl/session_id_table.sv -----
// session slot table top level: command sequencer, slot store and config
// depends on sid_pkg, sid_ram and sid_match
//
// A command is taken when start is high and busy is low; in_data carries the
// command, session identifier and psk flag. busy stays high until the result
// is presented. Each command produces exactly one result, shown on out_data
// for one cycle with out_valid high; the receiver cannot stall it.
// Invalid identifiers and unused codes answer in the cycle after start.
// Otherwise the sequencer walks the slot ram with one masked comparator, one
// slot per cycle behind a registered read. Assign walks twice (duplicate
// check, then first free slot). A new command can be started in the cycle
// its predecessor's result is shown.
// The config channel (cfg_valid/cfg_ready, index and data) is always ready
// and writes the peer and local capability registers, used when a slot is
// assigned or freed. Reset clears state, capabilities and per slot valid
// bits; a slot never written reads as free.
module session_id_table #(
  parameter int SESSION_SLOTS = sid_pkg::SESSION_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sid_pkg::in_t  in_data,
  output logic          out_valid,
  output sid_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [1:0]    cfg_data
);

  localparam int IW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int CW = $clog2(SESSION_SLOTS + 1);
  localparam int EW = sid_pkg::ENTRY_W;
  localparam int IDW = sid_pkg::ID_W;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  sid_pkg::out_t      out_r, out_nxt;
  logic [1:0]         peer_caps_r, peer_caps_nxt;
  logic [1:0]         local_caps_r, local_caps_nxt;
  logic [SESSION_SLOTS-1:0] valid_r, valid_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [IDW-1:0]     id_r, id_nxt;
  logic               psk_r, psk_nxt;
  logic [IDW-1:0]     key_r, key_nxt;
  logic [IDW-1:0]     mask_r, mask_nxt;
  logic               free_pass_r, free_pass_nxt;
  logic [CW-1:0]      iss_r, iss_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]      chk_idx_r, chk_idx_nxt;

  logic               ram_we;
  logic [EW-1:0]      ram_wdata;
  logic [EW-1:0]      ram_rdata;
  logic [EW-1:0]      entry;
  logic               hit;
  logic               last;
  logic [1:0]         cur_type;
  logic [IW+1:0]      idx_ext2;
  logic [IW+15:0]     idx_ext16;

  sid_ram #(
    .WIDTH (EW),
    .DEPTH (SESSION_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_idx_r),
    .wdata (ram_wdata),
    .raddr (iss_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign entry = valid_r[chk_idx_r] ? ram_rdata : {sid_pkg::ID_FREE, 3'b000};

  sid_match u_match (
    .data (entry[EW-1:3]),
    .key  (key_r),
    .mask (mask_r),
    .hit  (hit)
  );

  assign last      = (chk_idx_r == IW'(SESSION_SLOTS - 1));
  assign cur_type  = sid_pkg::caps_to_type(peer_caps_r & local_caps_r);
  assign idx_ext2  = {2'b00, chk_idx_r};
  assign idx_ext16 = {16'h0000, chk_idx_r};

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    peer_caps_nxt  = peer_caps_r;
    local_caps_nxt = local_caps_r;
    valid_nxt      = valid_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    psk_nxt        = psk_r;
    key_nxt        = key_r;
    mask_nxt       = mask_r;
    free_pass_nxt  = free_pass_r;
    iss_nxt        = iss_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    ram_we         = 1'b0;
    ram_wdata      = {sid_pkg::ID_FREE, 1'b0, cur_type};

    if (cfg_valid) begin
      unique case (cfg_index)
        sid_pkg::CFG_PEER_CAPS:  peer_caps_nxt  = cfg_data;
        sid_pkg::CFG_LOCAL_CAPS: local_caps_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt       = in_data.command;
          id_nxt        = in_data.sess_id;
          psk_nxt       = in_data.use_psk;
          free_pass_nxt = 1'b0;
          iss_nxt       = '0;
          out_nxt       = '0;
          key_nxt       = in_data.sess_id;
          mask_nxt      = sid_pkg::ID_FREE;
          unique case (in_data.command) inside
            sid_pkg::CMD_LOOKUP, sid_pkg::CMD_ASSIGN, sid_pkg::CMD_FREE: begin
              if (in_data.sess_id == sid_pkg::ID_FREE) begin
                out_nxt.status = sid_pkg::ST_INVALID;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            sid_pkg::CMD_ALLOC_REQ: begin
              key_nxt   = sid_pkg::ID_FREE;
              mask_nxt  = sid_pkg::HIGH_HALF;
              state_nxt = S_SCAN;
            end
            sid_pkg::CMD_ALLOC_RSP: begin
              key_nxt   = sid_pkg::ID_FREE;
              mask_nxt  = sid_pkg::LOW_HALF;
              state_nxt = S_SCAN;
            end
            default: begin
              out_nxt.status = sid_pkg::ST_INVALID;
              out_valid_nxt  = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (iss_r != CW'(SESSION_SLOTS)) begin
          iss_nxt     = iss_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[IW-1:0];
        end
        if (chk_vld_r && (hit || last)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          chk_vld_nxt   = 1'b0;
          out_nxt       = '0;
          unique case (cmd_r)
            sid_pkg::CMD_LOOKUP: begin
              if (hit) begin
                out_nxt.slot_index         = idx_ext2[1:0];
                out_nxt.entry_use_psk      = entry[2];
                out_nxt.entry_session_type = entry[1:0];
              end else begin
                out_nxt.status = sid_pkg::ST_NOT_FOUND;
              end
            end
            sid_pkg::CMD_FREE: begin
              if (hit) begin
                ram_we                   = 1'b1;
                valid_nxt[chk_idx_r]     = 1'b1;
                out_nxt.slot_index       = idx_ext2[1:0];
              end else begin
                out_nxt.status = sid_pkg::ST_NOT_FOUND;
              end
            end
            sid_pkg::CMD_ASSIGN: begin
              if (!free_pass_r) begin
                if (hit) begin
                  out_nxt.status = sid_pkg::ST_DUPLICATE;
                end else begin
                  // duplicate check passed, walk again for the first free slot
                  state_nxt     = S_SCAN;
                  out_valid_nxt = 1'b0;
                  out_nxt       = out_r;
                  free_pass_nxt = 1'b1;
                  key_nxt       = sid_pkg::ID_FREE;
                  iss_nxt       = '0;
                end
              end else if (hit) begin
                ram_we                     = 1'b1;
                ram_wdata                  = {id_r, psk_r, cur_type};
                valid_nxt[chk_idx_r]       = 1'b1;
                out_nxt.slot_index         = idx_ext2[1:0];
                out_nxt.entry_use_psk      = psk_r;
                out_nxt.entry_session_type = cur_type;
              end else begin
                out_nxt.status = sid_pkg::ST_FULL;
              end
            end
            default: begin
              if (hit) begin
                out_nxt.slot_index = idx_ext2[1:0];
                out_nxt.half_id    = sid_pkg::HALF_NONE - idx_ext16[15:0];
              end else begin
                out_nxt.status  = sid_pkg::ST_FULL;
                out_nxt.half_id = sid_pkg::HALF_NONE;
              end
            end
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      peer_caps_r  <= '0;
      local_caps_r <= '0;
      valid_r      <= '0;
      chk_vld_r    <= 1'b0;
      iss_r        <= '0;
      free_pass_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      peer_caps_r  <= peer_caps_nxt;
      local_caps_r <= local_caps_nxt;
      valid_r      <= valid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      iss_r        <= iss_nxt;
      free_pass_r  <= free_pass_nxt;
    end
    out_r     <= out_nxt;
    cmd_r     <= cmd_nxt;
    id_r      <= id_nxt;
    psk_r     <= psk_nxt;
    key_r     <= key_nxt;
    mask_r    <= mask_nxt;
    chk_idx_r <= chk_idx_nxt;
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for session_id_table: directed and random slot commands
// checked against an in-bench model of the slot table; depends on sid_pkg and the rtl
module tb;

  localparam int SLOTS = sid_pkg::SESSION_SLOTS_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 175;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sid_pkg::in_t in_data = '0;
  logic out_valid;
  sid_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [1:0] cfg_data = '0;

  session_id_table #(.SESSION_SLOTS(SLOTS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // table model
  logic [sid_pkg::ID_W-1:0] tbl_id [SLOTS];
  logic tbl_psk [SLOTS];
  logic [1:0] tbl_type [SLOTS];
  logic [1:0] peer_caps = '0;
  logic [1:0] local_caps = '0;

  sid_pkg::in_t pending_commands[$];
  sid_pkg::out_t expected_results[$];
  logic [sid_pkg::ID_W-1:0] id_pool [8];
  int idle_pct = 20;
  int idle_left = 0;
  int mismatch_cnt = 0;
  int stall_cycles = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_id[i] = sid_pkg::ID_FREE;
      tbl_psk[i] = 1'b0;
      tbl_type[i] = sid_pkg::TYPE_NONE;
    end
  end

  function automatic logic [1:0] caps_type();
    logic [1:0] both;
    both = peer_caps & local_caps;
    case (both)
      2'b00: return sid_pkg::TYPE_NONE;
      2'b11: return sid_pkg::TYPE_ENC_MAC;
      2'b10: return sid_pkg::TYPE_MAC;
      default: return sid_pkg::TYPE_BAD;
    endcase
  endfunction

  function automatic int find_slot(logic [sid_pkg::ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic sid_pkg::out_t predict_session_result(sid_pkg::in_t item);
    sid_pkg::out_t r;
    int k;
    logic [sid_pkg::ID_W-1:0] mask;
    r = '0;
    k = -1;
    case (item.command)
      sid_pkg::CMD_LOOKUP, sid_pkg::CMD_ASSIGN, sid_pkg::CMD_FREE: begin
        if (item.sess_id == sid_pkg::ID_FREE) begin
          r.status = sid_pkg::ST_INVALID;
        end else begin
          k = find_slot(item.sess_id);
          case (item.command)
            sid_pkg::CMD_LOOKUP: begin
              if (k < 0) begin
                r.status = sid_pkg::ST_NOT_FOUND;
              end else begin
                r.slot_index = k[1:0];
                r.entry_use_psk = tbl_psk[k];
                r.entry_session_type = tbl_type[k];
              end
            end
            sid_pkg::CMD_ASSIGN: begin
              if (k >= 0) begin
                r.status = sid_pkg::ST_DUPLICATE;
              end else begin
                k = find_slot(sid_pkg::ID_FREE);
                if (k < 0) begin
                  r.status = sid_pkg::ST_FULL;
                end else begin
                  tbl_id[k] = item.sess_id;
                  tbl_psk[k] = item.use_psk;
                  tbl_type[k] = caps_type();
                  r.slot_index = k[1:0];
                  r.entry_use_psk = item.use_psk;
                  r.entry_session_type = tbl_type[k];
                end
              end
            end
            default: begin
              if (k < 0) begin
                r.status = sid_pkg::ST_NOT_FOUND;
              end else begin
                tbl_id[k] = sid_pkg::ID_FREE;
                tbl_psk[k] = 1'b0;
                tbl_type[k] = caps_type();
                r.slot_index = k[1:0];
              end
            end
          endcase
        end
      end
      sid_pkg::CMD_ALLOC_REQ, sid_pkg::CMD_ALLOC_RSP: begin
        mask = (item.command == sid_pkg::CMD_ALLOC_REQ) ? sid_pkg::HIGH_HALF
                                                        : sid_pkg::LOW_HALF;
        for (int i = 0; i < SLOTS; i++)
          if (k < 0 && (tbl_id[i] & mask) == mask) k = i;
        if (k < 0) begin
          r.status = sid_pkg::ST_FULL;
          r.half_id = sid_pkg::HALF_NONE;
        end else begin
          r.slot_index = k[1:0];
          r.half_id = sid_pkg::HALF_NONE - 16'(k);
        end
      end
      default: r.status = sid_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic sid_pkg::in_t make_item(logic [2:0] cmd,
                                             logic [sid_pkg::ID_W-1:0] id, logic psk);
    sid_pkg::in_t t;
    t.command = cmd;
    t.sess_id = id;
    t.use_psk = psk;
    return t;
  endfunction

  function automatic logic [sid_pkg::ID_W-1:0] new_id();
    case ($urandom_range(0, 3))
      0: return {16'hFFFF, 16'($urandom)};
      1: return {16'($urandom), 16'hFFFF};
      default: return $urandom;
    endcase
  endfunction

  function automatic sid_pkg::in_t random_command();
    int r;
    logic [2:0] cmd;
    logic [sid_pkg::ID_W-1:0] id;
    r = $urandom_range(0, 99);
    if (r < 22) cmd = sid_pkg::CMD_LOOKUP;
    else if (r < 52) cmd = sid_pkg::CMD_ASSIGN;
    else if (r < 74) cmd = sid_pkg::CMD_FREE;
    else if (r < 83) cmd = sid_pkg::CMD_ALLOC_REQ;
    else if (r < 92) cmd = sid_pkg::CMD_ALLOC_RSP;
    else cmd = 3'(sid_pkg::CMD_ALLOC_RSP + $urandom_range(1, 3));
    r = $urandom_range(0, 99);
    if (r < 5) id = sid_pkg::ID_FREE;
    else if (r < 75) id = id_pool[$urandom_range(0, 7)];
    else id = new_id();
    return make_item(cmd, id, 1'($urandom));
  endfunction

  // driver: one command per handshake, random idle bursts after acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_session_result(in_data));
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
          idle_left = $urandom_range(1, 13);
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
          start <= 1'b0;
        end else if (pending_commands.size() > 0) begin
          in_data <= pending_commands.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be stalled, check each against the oldest expectation
  always @(posedge clk) begin
    sid_pkg::out_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: status %0d slot %0d half %h psk %0d type %0d",
                   out_data.status, out_data.slot_index, out_data.half_id,
                   out_data.entry_use_psk, out_data.entry_session_type);
        mismatch_cnt++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.status !== e.status || out_data.slot_index !== e.slot_index ||
            out_data.half_id !== e.half_id || out_data.entry_use_psk !== e.entry_use_psk ||
            out_data.entry_session_type !== e.entry_session_type) begin
          if (mismatch_cnt < 10) begin
            $display("mismatch: exp status %0d slot %0d half %h psk %0d type %0d",
                     e.status, e.slot_index, e.half_id, e.entry_use_psk,
                     e.entry_session_type);
            $display("          got status %0d slot %0d half %h psk %0d type %0d",
                     out_data.status, out_data.slot_index, out_data.half_id,
                     out_data.entry_use_psk, out_data.entry_session_type);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic drain_commands();
    while (!(pending_commands.size() == 0 && !start && !busy &&
             expected_results.size() == 0))
      @(negedge clk);
  endtask

  task automatic write_caps(logic idx, logic [1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sid_pkg::CFG_PEER_CAPS) peer_caps = val;
    else local_caps = val;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int peer_list [7] = '{3, 1, 3, 0, 3, 0, 2};
    int local_list [7] = '{3, 3, 2, 3, 1, 0, 2};
    int idle_list [7] = '{25, 0, 40, 10, 60, 25, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // invalid and unknown ids, fill to full, half allocation hits and misses
    pending_commands.push_back(make_item(sid_pkg::CMD_LOOKUP, sid_pkg::ID_FREE, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, sid_pkg::ID_FREE, 1'b1));
    pending_commands.push_back(make_item(sid_pkg::CMD_FREE, sid_pkg::ID_FREE, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_LOOKUP, 32'h0, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_FREE, 32'h1234_5678, 1'b1));
    pending_commands.push_back(make_item(sid_pkg::CMD_ALLOC_REQ, 32'h0, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ALLOC_RSP, 32'h0, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'h0, 1'b1));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'h0, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'hFFFF_0001, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'h0001_FFFF, 1'b1));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'hFFFF_FFFE, 1'b1));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'hA5A5_A5A5, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ALLOC_REQ, 32'h0, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ALLOC_RSP, 32'h0, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_LOOKUP, 32'h0001_FFFF, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_FREE, 32'h0, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ALLOC_REQ, 32'h0, 1'b0));
    pending_commands.push_back(make_item(3'(sid_pkg::CMD_ALLOC_RSP + 1), 32'h0, 1'b1));
    pending_commands.push_back(make_item(3'(sid_pkg::CMD_ALLOC_RSP + 3), sid_pkg::ID_FREE,
                                         1'b1));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'h5, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_FREE, 32'hFFFF_0001, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_FREE, 32'hFFFF_FFFE, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'h11, 1'b1));
    pending_commands.push_back(make_item(sid_pkg::CMD_ASSIGN, 32'h22, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ALLOC_REQ, 32'h0, 1'b0));
    pending_commands.push_back(make_item(sid_pkg::CMD_ALLOC_RSP, 32'h0, 1'b0));
    drain_commands();

    for (int p = 0; p < 7; p++) begin
      if (p == 5) begin
        peer_list[p] = $urandom_range(0, 3);
        local_list[p] = $urandom_range(0, 3);
      end
      write_caps(sid_pkg::CFG_PEER_CAPS, 2'(peer_list[p]));
      write_caps(sid_pkg::CFG_LOCAL_CAPS, 2'(local_list[p]));
      idle_pct = idle_list[p];
      // keep live ids in the pool so lookups, duplicates and frees keep hitting
      for (int i = 0; i < 8; i++)
        id_pool[i] = (i < SLOTS && tbl_id[i] != sid_pkg::ID_FREE) ? tbl_id[i] : new_id();
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_commands.push_back(random_command());
      drain_commands();
    end

    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sid_pkg.sv
hw/rtl/sid_ram.sv
hw/rtl/sid_match.sv
hw/rtl/session_id_table.sv
tb/sv/tb.sv
